>>> design/modular_discriminant_residue_sieve_defines.svh
// Assertion macros shared by the residue sieve RTL.
`ifndef MODULAR_DISCRIMINANT_RESIDUE_SIEVE_DEFINES_SVH
`define MODULAR_DISCRIMINANT_RESIDUE_SIEVE_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define MDRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define MDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mdrs_pkg.sv
// Shared types, constants and the sequencer program of the residue sieve.
package mdrs_pkg;

  localparam int MAX_PRIMES_DEF   = 60;
  localparam int RESIDUE_BITS_DEF = 10;
  localparam int CNT_W            = 6;
  localparam int REG_AW           = 5;
  localparam int PC_W             = 6;
  localparam logic [CNT_W-1:0] THRESH_RESET = 6'd40;

  // Operations of the sequencer program.
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_MULC, OP_SQR,
    OP_SKIPZ, OP_TALLY, OP_LOOP, OP_EULER, OP_DONE
  } op_t;

  // Where the second operand comes from.
  typedef enum logic [1:0] {BK_REG, BK_FIELD, BK_CONST} bk_t;

  typedef struct packed {
    op_t               op;
    logic [REG_AW-1:0] dst;
    logic [REG_AW-1:0] a;
    bk_t               bk;
    logic [REG_AW-1:0] bi;
  } instr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            fetch;
    logic            start_mul;
    logic            wr_alu;
    logic            wr_mul;
    logic            shift_exp;
    logic [PC_W-1:0] pc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic last;
    logic a_zero;
    logic a_one;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
  } stat_t;

  // Register file slots.
  localparam logic [REG_AW-1:0] R_ONE = 5'd0,  R_Z1 = 5'd1,  R_Z2 = 5'd2,  R_IZ1 = 5'd3;
  localparam logic [REG_AW-1:0] R_IZ2 = 5'd4,  R_IT1 = 5'd5, R_IT2 = 5'd6, R_SG = 5'd7;
  localparam logic [REG_AW-1:0] R_PD = 5'd8,   R_TA = 5'd9,  R_A = 5'd10,  R_C = 5'd11;
  localparam logic [REG_AW-1:0] R_T = 5'd12,   R_U = 5'd13,  R_X = 5'd14,  R_Y = 5'd15;
  localparam logic [REG_AW-1:0] R_B = 5'd16,   R_A2 = 5'd17, R_A3 = 5'd18, R_U2 = 5'd19;
  localparam logic [REG_AW-1:0] R_U3 = 5'd20,  R_B2 = 5'd21, R_B3 = 5'd22, R_C2 = 5'd23;
  localparam logic [REG_AW-1:0] R_W = 5'd24,   R_Q = 5'd25,  R_R = 5'd26;

  // Input field selectors.
  localparam logic [REG_AW-1:0] F_Z1 = 5'd0, F_IZ1 = 5'd1, F_IT1 = 5'd2, F_Z2 = 5'd3;
  localparam logic [REG_AW-1:0] F_IZ2 = 5'd4, F_IT2 = 5'd5, F_SG = 5'd6, F_PD = 5'd7;
  localparam logic [REG_AW-1:0] F_TA = 5'd8;

  // Small multiplier constants of the discriminant.
  localparam logic [REG_AW-1:0] K_1 = 5'd1, K_2 = 5'd2, K_3 = 5'd3, K_4 = 5'd4;
  localparam logic [REG_AW-1:0] K_18 = 5'd18, K_27 = 5'd27;

  localparam logic [PC_W-1:0] PC_POW_LOOP = 6'd50;

  function automatic instr_t mk(op_t op, logic [REG_AW-1:0] dst, logic [REG_AW-1:0] a,
                                bk_t bk, logic [REG_AW-1:0] bi);
    instr_t r;
    r.op  = op;
    r.dst = dst;
    r.a   = a;
    r.bk  = bk;
    r.bi  = bi;
    return r;
  endfunction

  // Program: reduce inputs, build A, C, T, u, Bn, W, then the Euler power of W*u.
  function automatic instr_t mdrs_instr(logic [PC_W-1:0] pc);
    instr_t r;
    unique case (pc)
      6'd0:  r = mk(OP_MUL, R_Z1,  R_ONE, BK_FIELD, F_Z1);
      6'd1:  r = mk(OP_MUL, R_Z2,  R_ONE, BK_FIELD, F_Z2);
      6'd2:  r = mk(OP_MUL, R_IZ1, R_ONE, BK_FIELD, F_IZ1);
      6'd3:  r = mk(OP_MUL, R_IZ2, R_ONE, BK_FIELD, F_IZ2);
      6'd4:  r = mk(OP_MUL, R_IT1, R_ONE, BK_FIELD, F_IT1);
      6'd5:  r = mk(OP_MUL, R_IT2, R_ONE, BK_FIELD, F_IT2);
      6'd6:  r = mk(OP_MUL, R_SG,  R_ONE, BK_FIELD, F_SG);
      6'd7:  r = mk(OP_MUL, R_PD,  R_ONE, BK_FIELD, F_PD);
      6'd8:  r = mk(OP_MUL, R_TA,  R_ONE, BK_FIELD, F_TA);
      6'd9:  r = mk(OP_SUB, R_A,   R_SG,  BK_REG,   R_Z1);
      6'd10: r = mk(OP_SUB, R_A,   R_A,   BK_REG,   R_Z2);
      6'd11: r = mk(OP_MUL, R_C,   R_IZ1, BK_REG,   R_IZ2);
      6'd12: r = mk(OP_MUL, R_C,   R_PD,  BK_REG,   R_C);
      6'd13: r = mk(OP_SUB, R_T,   R_TA,  BK_REG,   R_IT1);
      6'd14: r = mk(OP_SUB, R_T,   R_T,   BK_REG,   R_IT2);
      6'd15: r = mk(OP_SUB, R_U,   R_ONE, BK_REG,   R_T);
      6'd16: r = mk(OP_SKIPZ, R_U, R_U,   BK_REG,   R_U);
      6'd17: r = mk(OP_SUB, R_X,   R_ONE, BK_REG,   R_A);
      6'd18: r = mk(OP_SUB, R_X,   R_X,   BK_REG,   R_C);
      6'd19: r = mk(OP_MUL, R_X,   R_T,   BK_REG,   R_X);
      6'd20: r = mk(OP_MUL, R_Y,   R_ONE, BK_CONST, K_3);
      6'd21: r = mk(OP_SUB, R_B,   R_X,   BK_REG,   R_Y);
      6'd22: r = mk(OP_MUL, R_Y,   R_A,   BK_CONST, K_2);
      6'd23: r = mk(OP_ADD, R_B,   R_B,   BK_REG,   R_Y);
      6'd24: r = mk(OP_MUL, R_A2,  R_A,   BK_REG,   R_A);
      6'd25: r = mk(OP_MUL, R_A3,  R_A2,  BK_REG,   R_A);
      6'd26: r = mk(OP_MUL, R_U2,  R_U,   BK_REG,   R_U);
      6'd27: r = mk(OP_MUL, R_U3,  R_U2,  BK_REG,   R_U);
      6'd28: r = mk(OP_MUL, R_B2,  R_B,   BK_REG,   R_B);
      6'd29: r = mk(OP_MUL, R_B3,  R_B2,  BK_REG,   R_B);
      6'd30: r = mk(OP_MUL, R_C2,  R_C,   BK_REG,   R_C);
      6'd31: r = mk(OP_MUL, R_W,   R_A,   BK_CONST, K_18);
      6'd32: r = mk(OP_MUL, R_W,   R_W,   BK_REG,   R_B);
      6'd33: r = mk(OP_MUL, R_W,   R_W,   BK_REG,   R_C);
      6'd34: r = mk(OP_MUL, R_W,   R_W,   BK_REG,   R_U2);
      6'd35: r = mk(OP_MUL, R_X,   R_A3,  BK_CONST, K_4);
      6'd36: r = mk(OP_MUL, R_X,   R_X,   BK_REG,   R_C);
      6'd37: r = mk(OP_MUL, R_X,   R_X,   BK_REG,   R_U3);
      6'd38: r = mk(OP_SUB, R_W,   R_W,   BK_REG,   R_X);
      6'd39: r = mk(OP_MUL, R_X,   R_A2,  BK_REG,   R_B2);
      6'd40: r = mk(OP_MUL, R_X,   R_X,   BK_REG,   R_U);
      6'd41: r = mk(OP_ADD, R_W,   R_W,   BK_REG,   R_X);
      6'd42: r = mk(OP_MUL, R_X,   R_B3,  BK_CONST, K_4);
      6'd43: r = mk(OP_SUB, R_W,   R_W,   BK_REG,   R_X);
      6'd44: r = mk(OP_MUL, R_X,   R_C2,  BK_CONST, K_27);
      6'd45: r = mk(OP_MUL, R_X,   R_X,   BK_REG,   R_U3);
      6'd46: r = mk(OP_SUB, R_W,   R_W,   BK_REG,   R_X);
      6'd47: r = mk(OP_TALLY, R_W, R_W,   BK_REG,   R_W);
      6'd48: r = mk(OP_MUL, R_Q,   R_W,   BK_REG,   R_U);
      6'd49: r = mk(OP_MUL, R_R,   R_ONE, BK_CONST, K_1);
      6'd50: r = mk(OP_MULC, R_R,  R_R,   BK_REG,   R_Q);
      6'd51: r = mk(OP_SQR, R_Q,   R_Q,   BK_REG,   R_Q);
      6'd52: r = mk(OP_LOOP, R_R,  R_R,   BK_REG,   R_R);
      6'd53: r = mk(OP_EULER, R_R, R_R,   BK_REG,   R_R);
      default: r = mk(OP_DONE, R_ONE, R_ONE, BK_REG, R_ONE);
    endcase
    return r;
  endfunction

endpackage

>>> design/mdrs_modmul.sv
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module mdrs_modmul import mdrs_pkg::*; #(
  parameter int RB = RESIDUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [RB-1:0] a,
  input  logic [RB-1:0] b,
  input  logic [RB-1:0] p,
  output logic          done,
  output logic [RB-1:0] prod
);

  localparam int CW = $clog2(RB + 1);

  logic [RB+1:0] acc;
  logic [RB-1:0] a_q;
  logic [RB-1:0] b_sh;
  logic [RB-1:0] p_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RB+1:0] t0, t1, t2, pw;

  // Double, add the multiplicand when the bit is set, then fold back below p.
  always_comb begin
    pw = {2'b00, p_q};
    t0 = {acc[RB:0], 1'b0} + (b_sh[RB-1] ? {2'b00, a_q} : '0);
    t1 = (t0 >= pw) ? t0 - pw : t0;
    t2 = (t1 >= pw) ? t1 - pw : t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_q  <= a;
      b_sh <= b;
      p_q  <= p;
      cnt  <= CW'(RB);
    end else if (busy) begin
      acc  <= t2;
      b_sh <= b_sh << 1;
      cnt  <= cnt - CW'(1);
    end
  end

  assign prod = acc[RB-1:0];

endmodule

>>> design/mdrs_datapath.sv
// Datapath: item registers, register file, modular add/subtract and multiplier.
module mdrs_datapath import mdrs_pkg::*; #(
  parameter int RB    = RESIDUE_BITS_DEF,
  parameter int IN_DW = 112
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_DW-1:0] in_data,
  input  logic             in_last,
  input  cmd_t             cmd,
  output stat_t            st
);

  localparam int RW     = RB + 1;
  localparam int O_Z1   = RB;
  localparam int O_IZ1  = RB + RW;
  localparam int O_IT1  = RB + 2 * RW;
  localparam int O_Z2   = RB + 3 * RW;
  localparam int O_IZ2  = RB + 4 * RW;
  localparam int O_IT2  = RB + 5 * RW;
  localparam int O_SG   = RB + 6 * RW;
  localparam int O_PD   = 2 * RB + 6 * RW;
  localparam int O_TA   = 3 * RB + 6 * RW;
  localparam int RF_D   = 2 ** REG_AW;

  instr_t        ins;
  logic [RB-1:0] p;
  logic [RB-1:0] fz1, fiz1, fit1, fz2, fiz2, fit2, fsg, fpd, fta;
  logic          skip_q, last_q;
  logic [RB-2:0] expo;
  logic [RB-1:0] rf [RF_D];
  logic [RB-1:0] rd_a, rd_b, b_alt;
  bk_t           bk_q;
  logic [RB-1:0] b_op, alu, fsel, prime_in, pm1;
  logic [RB:0]   sum, dif;
  logic          neg_any, mul_done;
  logic [RB-1:0] mul_prod;

  assign ins      = mdrs_instr(cmd.pc);
  assign prime_in = in_data[RB-1:0];
  assign pm1      = prime_in - RB'(1);
  assign neg_any  = in_data[O_Z1+RB] | in_data[O_IZ1+RB] | in_data[O_IT1+RB]
                  | in_data[O_Z2+RB] | in_data[O_IZ2+RB] | in_data[O_IT2+RB];

  // Capture one item; negative residues or a modulus below two skip it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p      <= prime_in;
      fz1    <= in_data[O_Z1 +: RB];
      fiz1   <= in_data[O_IZ1 +: RB];
      fit1   <= in_data[O_IT1 +: RB];
      fz2    <= in_data[O_Z2 +: RB];
      fiz2   <= in_data[O_IZ2 +: RB];
      fit2   <= in_data[O_IT2 +: RB];
      fsg    <= in_data[O_SG +: RB];
      fpd    <= in_data[O_PD +: RB];
      fta    <= in_data[O_TA +: RB];
      last_q <= in_last;
      skip_q <= neg_any | (prime_in < RB'(2));
      expo   <= pm1[RB-1:1];
    end else if (cmd.shift_exp) begin
      expo   <= expo >> 1;
    end
  end

  // Field selection for reducing a raw input.
  always_comb begin
    unique case (ins.bi)
      F_Z1:    fsel = fz1;
      F_IZ1:   fsel = fiz1;
      F_IT1:   fsel = fit1;
      F_Z2:    fsel = fz2;
      F_IZ2:   fsel = fiz2;
      F_IT2:   fsel = fit2;
      F_SG:    fsel = fsg;
      F_PD:    fsel = fpd;
      F_TA:    fsel = fta;
      default: fsel = '0;
    endcase
  end

  // Operand fetch from the register file.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_a  <= rf[ins.a];
      rd_b  <= rf[ins.bi];
      bk_q  <= ins.bk;
      b_alt <= (ins.bk == BK_FIELD) ? fsel : RB'(ins.bi);
    end
  end

  assign b_op = (bk_q == BK_REG) ? rd_b : b_alt;

  // Modular add and subtract of reduced values.
  always_comb begin
    sum = {1'b0, rd_a} + {1'b0, b_op};
    dif = {1'b0, rd_a} - {1'b0, b_op};
    if (ins.op == OP_ADD) begin
      alu = (sum >= {1'b0, p}) ? RB'(sum - {1'b0, p}) : sum[RB-1:0];
    end else begin
      alu = dif[RB] ? RB'(dif + {1'b0, p}) : dif[RB-1:0];
    end
  end

  // Register file write port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rf[R_ONE] <= RB'(1);
    end else if (cmd.wr_alu) begin
      rf[ins.dst] <= alu;
    end else if (cmd.wr_mul) begin
      rf[ins.dst] <= mul_prod;
    end
  end

  mdrs_modmul #(.RB(RB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul),
    .a     (rd_a),
    .b     (b_op),
    .p     (p),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign st.skip     = skip_q;
  assign st.last     = last_q;
  assign st.a_zero   = (rd_a == '0);
  assign st.a_one    = (rd_a == RB'(1));
  assign st.exp_zero = (expo == '0);
  assign st.exp_lsb  = expo[0];
  assign st.mul_done = mul_done;

endmodule

>>> design/mdrs_ctrl.sv
// Controller: steps through the program, keeps the pair state and the result register.
module mdrs_ctrl import mdrs_pkg::*; #(
  parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             cfg_valid,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             out_cand,
  output logic [CNT_W-1:0] out_count,
  input  stat_t            st,
  output cmd_t             cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_FETCH, S_EXEC, S_MUL, S_FINISH} state_t;

  state_t           state;
  logic [PC_W-1:0]  pc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] thresh;
  logic             passing;
  logic             post_res;
  instr_t           ins;
  op_t              op;

  assign ins      = mdrs_instr(pc);
  assign op       = ins.op;
  assign s_tready = (state == S_IDLE);

  // A last item posts its result once the output register is free.
  assign post_res = (state == S_FINISH) && st.last && (!m_tvalid || m_tready);

  // Commands to the datapath.
  always_comb begin
    cmd.pc        = pc;
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.fetch     = (state == S_FETCH);
    cmd.start_mul = (state == S_EXEC) &&
                    (op == OP_MUL || op == OP_SQR || (op == OP_MULC && st.exp_lsb));
    cmd.wr_alu    = (state == S_EXEC) && (op == OP_ADD || op == OP_SUB);
    cmd.wr_mul    = (state == S_MUL) && st.mul_done;
    cmd.shift_exp = (state == S_MUL) && st.mul_done && (op == OP_SQR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      count    <= '0;
      passing  <= 1'b1;
      thresh   <= THRESH_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thresh <= cfg_data;
      end
      if (post_res) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_CHECK;
        end
        S_CHECK: begin
          pc    <= '0;
          state <= (!passing || st.skip) ? S_FINISH : S_FETCH;
        end
        S_FETCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op)
            OP_ADD, OP_SUB: begin
              pc    <= pc + PC_W'(1);
              state <= S_FETCH;
            end
            OP_MUL, OP_SQR: begin
              state <= S_MUL;
            end
            OP_MULC: begin
              if (st.exp_lsb) begin
                state <= S_MUL;
              end else begin
                pc    <= pc + PC_W'(1);
                state <= S_FETCH;
              end
            end
            OP_SKIPZ: begin
              if (st.a_zero) begin
                state <= S_FINISH;
              end else begin
                pc    <= pc + PC_W'(1);
                state <= S_FETCH;
              end
            end
            OP_TALLY: begin
              if (st.a_zero) begin
                state <= S_FINISH;
              end else begin
                if (count < CNT_W'(MAX_PRIMES)) count <= count + CNT_W'(1);
                pc    <= pc + PC_W'(1);
                state <= S_FETCH;
              end
            end
            OP_LOOP: begin
              pc    <= st.exp_zero ? pc + PC_W'(1) : PC_POW_LOOP;
              state <= S_FETCH;
            end
            OP_EULER: begin
              if (!st.a_one) passing <= 1'b0;
              state <= S_FINISH;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_MUL: begin
          if (st.mul_done) begin
            pc    <= pc + PC_W'(1);
            state <= S_FETCH;
          end
        end
        S_FINISH: begin
          // A last item posts the result once the output register is free.
          if (!st.last) begin
            state <= S_IDLE;
          end else if (post_res) begin
            out_cand  <= passing && (count >= thresh);
            out_count <= count;
            count     <= '0;
            passing   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/modular_discriminant_residue_sieve.sv
// Top level of the modular discriminant residue sieve.
//
// One request on the s_ channel carries one prime of a candidate pair; s_tlast
// marks the final prime of the pair, and only that request yields a result on
// the m_ channel: is_candidate and the count of primes with nonzero W.
// The threshold register is written through cfg_valid/cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
// A tested item runs a fixed program on one bit-serial modular multiplier;
// the Euler power adds one or two products per exponent bit. Items whose u or
// W is zero stop early. Items that are skipped (negative residue, modulus
// below two, or a pair that already failed) go straight to the finish state.
// One item is worked on at a time; s_tready is high while the block is idle.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; a second result waits until the first is taken.
// Reset clears the pair state, drops m_tvalid and sets the threshold to 40.
module modular_discriminant_residue_sieve import mdrs_pkg::*; #(
  parameter int MAX_PRIMES   = MAX_PRIMES_DEF,
  parameter int RESIDUE_BITS = RESIDUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // prime, z1_res, z1_inv_res, z1_tinv_res, z2_res, z2_inv_res, z2_tinv_res,
  // sigma_res, product_res, tau_res, then zero fill
  input  logic [((10*RESIDUE_BITS+6+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tlast,
  // is_candidate, nonzero_count, then zero fill
  output logic [7:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  `include "modular_discriminant_residue_sieve_defines.svh"

  localparam int IN_DW = ((10 * RESIDUE_BITS + 6 + 7) / 8) * 8;

  cmd_t             cmd;
  stat_t            st;
  logic             out_cand;
  logic [CNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_count, out_cand};

  mdrs_ctrl #(.MAX_PRIMES(MAX_PRIMES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_cand  (out_cand),
    .out_count (out_count),
    .st        (st),
    .cmd       (cmd)
  );

  mdrs_datapath #(.RB(RESIDUE_BITS), .IN_DW(IN_DW)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_tdata),
    .in_last (s_tlast),
    .cmd     (cmd),
    .st      (st)
  );

  // The reported count never passes its saturation limit.
  `MDRS_ASSERT_SAME(a_count_limit, m_tvalid, out_count <= CNT_W'(MAX_PRIMES), "count above limit")
  // After a request is taken the block is busy in the next cycle.
  `MDRS_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready right after take")
  // A multiplier result only arrives while the controller waits for it.
  `MDRS_ASSERT_SAME(a_mul_wait, st.mul_done, !s_tready, "product while idle")

endmodule
